FILE: hw/rtl/rme_pkg.sv
// Shared types, constants and microcode program for the modular exponentiation block.
package rme_pkg;

  // Field and register widths of the ports.
  localparam int DATA_WIDTH          = 32;
  localparam int CFG_INDEX_WIDTH     = 2;
  localparam int OPERAND_WIDTH_DEF   = 32;

  // Register reset values.
  localparam logic [DATA_WIDTH-1:0] RESET_MODULUS  = 32'd91;
  localparam logic [DATA_WIDTH-1:0] RESET_PUB_EXP  = 32'd5;
  localparam logic [DATA_WIDTH-1:0] RESET_PRIV_EXP = 32'd29;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PUB_EXP  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRIV_EXP = 2'd2;

  // Opcode of an input item.
  localparam logic OPC_ENCRYPT = 1'b0;
  localparam logic OPC_DECRYPT = 1'b1;

  // Program counter width and program addresses.
  localparam int PC_WIDTH = 4;
  typedef logic [PC_WIDTH-1:0] pc_t;

  localparam pc_t PC_IDLE      = 4'd0;
  localparam pc_t PC_EXP_TEST  = 4'd1;
  localparam pc_t PC_MOD_TEST  = 4'd2;
  localparam pc_t PC_RED_START = 4'd3;
  localparam pc_t PC_RED_RUN   = 4'd4;
  localparam pc_t PC_BIT_TEST  = 4'd5;
  localparam pc_t PC_MUL_START = 4'd6;
  localparam pc_t PC_MUL_RUN   = 4'd7;
  localparam pc_t PC_SQR_START = 4'd8;
  localparam pc_t PC_SQR_RUN   = 4'd9;
  localparam pc_t PC_SHIFT     = 4'd10;
  localparam pc_t PC_TO_OUT    = 4'd11;
  localparam pc_t PC_CLEAR     = 4'd12;
  localparam pc_t PC_OUT       = 4'd13;

  // Datapath operation of one step.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_MSTART,
    OP_MRUN,
    OP_SHIFT,
    OP_CLEAR,
    OP_OUT
  } op_t;

  // Operand sources for the modular multiplier.
  typedef enum logic [1:0] {
    SRC_ONE,
    SRC_MSG,
    SRC_SQ,
    SRC_ACC
  } src_t;

  // Destination of a finished product.
  typedef enum logic {
    DST_SQ,
    DST_ACC
  } dst_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_EXP_ZERO,
    C_MOD_ONE,
    C_MUL_BUSY,
    C_BIT_CLEAR,
    C_MORE_BITS,
    C_OUT_BUSY
  } cond_t;

  // One control word.
  typedef struct packed {
    op_t   op;
    src_t  a_sel;
    src_t  b_sel;
    dst_t  dst;
    cond_t cond;
    pc_t   target;
    logic  done;
  } ctrl_t;

  // Microcode program: square-and-multiply with an interleaved modular multiplier.
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_NOP, a_sel: SRC_ONE, b_sel: SRC_MSG, dst: DST_SQ,
          cond: C_NEVER, target: PC_IDLE, done: 1'b0};
    case (pc)
      PC_IDLE: begin
        w.cond   = C_NO_INPUT;
        w.target = PC_IDLE;
      end
      PC_EXP_TEST: begin
        w.cond   = C_EXP_ZERO;
        w.target = PC_OUT;
      end
      PC_MOD_TEST: begin
        w.cond   = C_MOD_ONE;
        w.target = PC_CLEAR;
      end
      PC_RED_START: begin
        w.op    = OP_MSTART;
        w.a_sel = SRC_ONE;
        w.b_sel = SRC_MSG;
      end
      PC_RED_RUN: begin
        w.op     = OP_MRUN;
        w.dst    = DST_SQ;
        w.cond   = C_MUL_BUSY;
        w.target = PC_RED_RUN;
      end
      PC_BIT_TEST: begin
        w.cond   = C_BIT_CLEAR;
        w.target = PC_SQR_START;
      end
      PC_MUL_START: begin
        w.op    = OP_MSTART;
        w.a_sel = SRC_SQ;
        w.b_sel = SRC_ACC;
      end
      PC_MUL_RUN: begin
        w.op     = OP_MRUN;
        w.dst    = DST_ACC;
        w.cond   = C_MUL_BUSY;
        w.target = PC_MUL_RUN;
      end
      PC_SQR_START: begin
        w.op    = OP_MSTART;
        w.a_sel = SRC_SQ;
        w.b_sel = SRC_SQ;
      end
      PC_SQR_RUN: begin
        w.op     = OP_MRUN;
        w.dst    = DST_SQ;
        w.cond   = C_MUL_BUSY;
        w.target = PC_SQR_RUN;
      end
      PC_SHIFT: begin
        w.op     = OP_SHIFT;
        w.cond   = C_MORE_BITS;
        w.target = PC_BIT_TEST;
      end
      PC_TO_OUT: begin
        w.cond   = C_ALWAYS;
        w.target = PC_OUT;
      end
      PC_CLEAR: begin
        w.op = OP_CLEAR;
      end
      PC_OUT: begin
        w.op     = OP_OUT;
        w.cond   = C_OUT_BUSY;
        w.target = PC_OUT;
        w.done   = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/rsa_modular_exponentiation_top.sv
// Microcoded modular exponentiation engine with key registers and output register.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   opcode, message
//   out       output     out_valid / out_stall result
//   cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// The serial modular multiplier handles one multiplier bit per cycle. An exponent of zero
// skips the multiplier and goes straight from the exponent test to the output step.
// Reset loads the key registers with their defaults and returns the sequencer to idle.
// A new item is taken only while the sequencer is idle; the result waits in the output
// register under stall, and the sequencer holds at its output step until it is free.
module rsa_modular_exponentiation_top #(
  parameter int OPERAND_WIDTH = rme_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  opcode,
  input  logic [rme_pkg::DATA_WIDTH-1:0]        message,
  // Output channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rme_pkg::DATA_WIDTH-1:0]        result,
  // Configuration channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rme_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [rme_pkg::DATA_WIDTH-1:0]        cfg_data
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(OPERAND_WIDTH);

  // Key registers.
  logic [rme_pkg::DATA_WIDTH-1:0] modulus;
  logic [rme_pkg::DATA_WIDTH-1:0] public_exponent;
  logic [rme_pkg::DATA_WIDTH-1:0] private_exponent;

  // Sequencer.
  rme_pkg::pc_t   upc;
  rme_pkg::pc_t   upc_next;
  rme_pkg::ctrl_t cw;
  logic           jump;

  // Working registers.
  logic [W-1:0]   msg;
  logic [W-1:0]   expo;
  logic [W-1:0]   sq;
  logic [W-1:0]   acc;

  // Serial modular multiplier.
  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic [W-1:0]   mr;
  logic [CW-1:0]  mcnt;
  logic [W-1:0]   mr_step;
  logic [W:0]     dbl;
  logic [W:0]     dbl_red;
  logic [W:0]     sum;
  logic [W:0]     sum_red;
  logic [W-1:0]   src_a;
  logic [W-1:0]   src_b;

  logic [W-1:0]   nw;
  logic           n_zero;
  logic           in_xfer;
  logic           out_xfer;
  logic           out_busy;

  assign nw        = modulus[W-1:0];
  assign n_zero    = (nw == '0);
  assign cfg_ready = 1'b1;
  assign in_stall  = (upc != rme_pkg::PC_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign out_busy  = out_valid && out_stall;
  assign cw        = rme_pkg::ucode(upc);

  // Key register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= rme_pkg::RESET_MODULUS;
      public_exponent  <= rme_pkg::RESET_PUB_EXP;
      private_exponent <= rme_pkg::RESET_PRIV_EXP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rme_pkg::REG_MODULUS:  modulus          <= cfg_data;
        rme_pkg::REG_PUB_EXP:  public_exponent  <= cfg_data;
        rme_pkg::REG_PRIV_EXP: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // Jump condition of the current control word.
  always_comb begin
    case (cw.cond)
      rme_pkg::C_NEVER:     jump = 1'b0;
      rme_pkg::C_ALWAYS:    jump = 1'b1;
      rme_pkg::C_NO_INPUT:  jump = !in_valid;
      rme_pkg::C_EXP_ZERO:  jump = (expo == '0);
      rme_pkg::C_MOD_ONE:   jump = (nw == W'(1));
      rme_pkg::C_MUL_BUSY:  jump = (mcnt != '0);
      rme_pkg::C_BIT_CLEAR: jump = !expo[0];
      rme_pkg::C_MORE_BITS: jump = (expo[W-1:1] != '0);
      rme_pkg::C_OUT_BUSY:  jump = out_busy;
      default:              jump = 1'b0;
    endcase
  end

  // Next program counter: jump, wrap to idle after the last step, or fall through.
  always_comb begin
    if (jump) begin
      upc_next = cw.target;
    end else if (cw.done) begin
      upc_next = rme_pkg::PC_IDLE;
    end else begin
      upc_next = upc + rme_pkg::pc_t'(1);
    end
  end

  // Multiplier operand selection.
  always_comb begin
    case (cw.a_sel)
      rme_pkg::SRC_ONE: src_a = W'(1);
      rme_pkg::SRC_MSG: src_a = msg;
      rme_pkg::SRC_SQ:  src_a = sq;
      rme_pkg::SRC_ACC: src_a = acc;
      default:          src_a = W'(1);
    endcase
    case (cw.b_sel)
      rme_pkg::SRC_ONE: src_b = W'(1);
      rme_pkg::SRC_MSG: src_b = msg;
      rme_pkg::SRC_SQ:  src_b = sq;
      rme_pkg::SRC_ACC: src_b = acc;
      default:          src_b = msg;
    endcase
  end

  // One multiplier step: double and reduce, then add the multiplicand and reduce.
  // With a zero modulus nothing is reduced and the value wraps at W bits.
  always_comb begin
    dbl     = {mr, 1'b0};
    dbl_red = (!n_zero && (dbl >= {1'b0, nw})) ? (dbl - {1'b0, nw}) : dbl;
    sum     = dbl_red + (mb[W-1] ? {1'b0, ma} : '0);
    sum_red = (!n_zero && (sum >= {1'b0, nw})) ? (sum - {1'b0, nw}) : sum;
    mr_step = sum_red[W-1:0];
  end

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= rme_pkg::PC_IDLE;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      // The output step loads a new result; otherwise a transfer empties the register.
      if (cw.op == rme_pkg::OP_OUT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers driven by the control word.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      msg  <= message[W-1:0];
      expo <= (opcode == rme_pkg::OPC_DECRYPT) ? private_exponent[W-1:0]
                                               : public_exponent[W-1:0];
      acc  <= W'(1);
    end
    case (cw.op)
      rme_pkg::OP_MSTART: begin
        ma   <= src_a;
        mb   <= src_b;
        mr   <= '0;
        mcnt <= CW'(W - 1);
      end
      rme_pkg::OP_MRUN: begin
        mr   <= mr_step;
        mb   <= {mb[W-2:0], 1'b0};
        mcnt <= mcnt - CW'(1);
        if (mcnt == '0) begin
          if (cw.dst == rme_pkg::DST_ACC) begin
            acc <= mr_step;
          end else begin
            sq <= mr_step;
          end
        end
      end
      rme_pkg::OP_SHIFT: begin
        expo <= expo >> 1;
      end
      rme_pkg::OP_CLEAR: begin
        acc <= '0;
      end
      rme_pkg::OP_OUT: begin
        if (!out_busy) begin
          result <= rme_pkg::DATA_WIDTH'(acc);
        end
      end
      default: ;
    endcase
  end

  // A result appears only from the output step.
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(upc) == rme_pkg::PC_OUT)
    else $error("result raised outside the output step");

  // An accepted item starts the program at the exponent test.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> upc == rme_pkg::PC_EXP_TEST)
    else $error("sequencer did not start after an input transfer");

  // The partial product stays reduced below a nonzero modulus.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (cw.op == rme_pkg::OP_MRUN && !n_zero) |-> mr < nw)
    else $error("partial product not reduced");

  // The multiplier leaves its run step once the bit count is spent.
  a_mul_end: assert property (@(posedge clk) disable iff (rst)
    (cw.op == rme_pkg::OP_MRUN && mcnt == '0) |=> cw.op != rme_pkg::OP_MRUN)
    else $error("multiplier ran past its last bit");

endmodule

FILE: tb/tb_rsa_modular_exponentiation_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the RSA modular exponentiation top level.
module tb_rsa_modular_exponentiation_top;

  // Index past the end of the key register file; writes to it are dropped.
  localparam logic [rme_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 29;

  typedef logic [rme_pkg::DATA_WIDTH-1:0] word_t;
  typedef struct {
    logic  opcode;
    word_t message;
  } msg_item_t;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  logic                                opcode    = rme_pkg::OPC_ENCRYPT;
  word_t                               message   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  word_t                               result;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [rme_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = rme_pkg::REG_MODULUS;
  word_t                               cfg_data  = '0;

  // Testbench copy of the key registers.
  word_t key_modulus  = rme_pkg::RESET_MODULUS;
  word_t key_pub_exp  = rme_pkg::RESET_PUB_EXP;
  word_t key_priv_exp = rme_pkg::RESET_PRIV_EXP;

  msg_item_t   send_queue[$];
  word_t       awaited_powers[$];
  int unsigned outstanding    = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned in_gap_left    = 0;
  int unsigned out_stall_left = 0;
  logic        quiet_phase    = 1'b0;

  rsa_modular_exponentiation_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .message   (message),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One modular product; a zero modulus means plain 32-bit wraparound.
  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                          input word_t n);
    logic [63:0] p;
    p = a * b;
    if (n == '0) return {32'b0, p[31:0]};
    return p % {32'b0, n};
  endfunction

  // Expected result: base raised to expo, reduced modulo n, by square-and-multiply.
  function automatic word_t mod_power(input word_t base, input word_t expo, input word_t n);
    logic [63:0] acc;
    logic [63:0] sq;
    if (expo == '0) return 1;
    if (n == 1) return '0;
    sq  = (n == '0) ? {32'b0, base} : {32'b0, base} % {32'b0, n};
    acc = 64'd1;
    for (int i = 0; i < rme_pkg::DATA_WIDTH; i++) begin
      if (expo[i]) acc = mul_mod(acc, sq, n);
      sq = mul_mod(sq, sq, n);
    end
    return acc[31:0];
  endfunction

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet_phase || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    if (pick < 98) return $urandom_range(5, 20);
    return $urandom_range(50, 200);
  endfunction

  // Exponent with a random bit length, sometimes an extreme.
  function automatic word_t random_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return word_t'($urandom()) >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic add_item(input logic op, input word_t msg);
    send_queue.push_back('{opcode: op, message: msg});
    outstanding++;
  endtask

  // Writes one key register and mirrors the write in the local copy.
  task automatic write_key(input logic [rme_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input word_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      rme_pkg::REG_MODULUS:  key_modulus  = value;
      rme_pkg::REG_PUB_EXP:  key_pub_exp  = value;
      rme_pkg::REG_PRIV_EXP: key_priv_exp = value;
      default: ;
    endcase
  endtask

  // Waits until every expected result has come back and the engine has settled.
  task automatic drain();
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: predicts each accepted transfer and loads the next item.
  always @(posedge clk) begin : driver
    msg_item_t item;
    if (rst) begin
      in_valid    <= 1'b0;
      in_gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_powers.push_back(mod_power(message,
            (opcode == rme_pkg::OPC_DECRYPT) ? key_priv_exp : key_pub_exp, key_modulus));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap_left != 0) begin
          in_gap_left <= in_gap_left - 1;
          in_valid    <= 1'b0;
        end else if (send_queue.size() != 0) begin
          item        = send_queue.pop_front();
          opcode      <= item.opcode;
          message     <= item.message;
          in_valid    <= 1'b1;
          in_gap_left <= idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result transfer and applies random stall.
  always @(posedge clk) begin : monitor
    word_t       want;
    int unsigned stretch;
    if (rst) begin
      out_stall      <= 1'b0;
      out_stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_powers.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, result);
          error_count++;
        end else begin
          want = awaited_powers.pop_front();
          outstanding--;
          if (result !== want) begin
            $display("%0t: result mismatch: expected %h, actual %h", $time, want, result);
            error_count++;
          end
        end
      end
      if (out_stall_left != 0) begin
        out_stall_left <= out_stall_left - 1;
        out_stall      <= 1'b1;
      end else begin
        stretch        = idle_length();
        out_stall      <= (stretch != 0);
        out_stall_left <= (stretch != 0) ? stretch - 1 : 0;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rsa_modular_exponentiation_top test failed");
      $finish;
    end
  end

  // Stimulus: directed key settings first, then random phases.
  initial begin : stimulus
    word_t modulus_pick;
    word_t msg;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset keys, message extremes around the modulus.
    add_item(rme_pkg::OPC_ENCRYPT, 32'd0);
    add_item(rme_pkg::OPC_ENCRYPT, 32'd1);
    add_item(rme_pkg::OPC_ENCRYPT, 32'd90);
    add_item(rme_pkg::OPC_DECRYPT, 32'd91);
    add_item(rme_pkg::OPC_DECRYPT, 32'd92);
    add_item(rme_pkg::OPC_ENCRYPT, 32'hFFFF_FFFF);
    add_item(rme_pkg::OPC_DECRYPT, 32'hFFFF_FFFF);
    drain();

    // Modulus one: zero exponent still gives one, any other exponent gives zero.
    write_key(rme_pkg::REG_MODULUS, 32'd1);
    write_key(rme_pkg::REG_PUB_EXP, 32'd0);
    write_key(rme_pkg::REG_PRIV_EXP, 32'd7);
    add_item(rme_pkg::OPC_ENCRYPT, 32'd5);
    add_item(rme_pkg::OPC_DECRYPT, 32'd5);
    add_item(rme_pkg::OPC_DECRYPT, 32'd0);
    drain();

    // Modulus zero: arithmetic wraps at 32 bits.
    quiet_phase = 1'b1;
    write_key(rme_pkg::REG_MODULUS, 32'd0);
    write_key(rme_pkg::REG_PUB_EXP, 32'hFFFF_FFFF);
    write_key(rme_pkg::REG_PRIV_EXP, 32'd0);
    add_item(rme_pkg::OPC_ENCRYPT, 32'hFFFF_FFFF);
    add_item(rme_pkg::OPC_ENCRYPT, 32'd3);
    add_item(rme_pkg::OPC_DECRYPT, 32'd12345);
    drain();

    // Largest modulus and exponent.
    quiet_phase = 1'b0;
    write_key(rme_pkg::REG_MODULUS, 32'hFFFF_FFFF);
    write_key(rme_pkg::REG_PRIV_EXP, 32'd1);
    add_item(rme_pkg::OPC_ENCRYPT, 32'hFFFF_FFFE);
    add_item(rme_pkg::OPC_DECRYPT, 32'hFFFF_FFFF);
    add_item(rme_pkg::OPC_DECRYPT, 32'd0);
    drain();

    // Smallest modulus above one; a write past the register file must leave the keys alone.
    write_key(rme_pkg::REG_MODULUS, 32'd2);
    write_key(rme_pkg::REG_PUB_EXP, 32'd3);
    write_key(rme_pkg::REG_PRIV_EXP, 32'd2);
    write_key(REG_UNUSED, 32'd0);
    add_item(rme_pkg::OPC_ENCRYPT, 32'd0);
    add_item(rme_pkg::OPC_ENCRYPT, 32'd1);
    add_item(rme_pkg::OPC_DECRYPT, 32'd3);
    add_item(rme_pkg::OPC_DECRYPT, 32'hFFFF_FFFF);
    drain();

    // Random phases, each with a fresh key setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: modulus_pick = '0;
        1: modulus_pick = 32'd1;
        2: modulus_pick = 32'd2;
        3: modulus_pick = '1;
        default: modulus_pick = word_t'($urandom()) >> $urandom_range(0, 28);
      endcase
      write_key(rme_pkg::REG_MODULUS, modulus_pick);
      write_key(rme_pkg::REG_PUB_EXP, random_exponent());
      write_key(rme_pkg::REG_PRIV_EXP, random_exponent());
      if ($urandom_range(0, 3) == 0) write_key(REG_UNUSED, $urandom());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0: msg = '1;
          1: msg = '0;
          2: msg = modulus_pick - 1;
          3: msg = modulus_pick;
          4, 5, 6: msg = (modulus_pick > 1) ? word_t'($urandom()) % modulus_pick : $urandom();
          default: msg = $urandom();
        endcase
        add_item($urandom_range(0, 1) ? rme_pkg::OPC_DECRYPT : rme_pkg::OPC_ENCRYPT, msg);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("rsa_modular_exponentiation_top test passed");
    end else begin
      $display("rsa_modular_exponentiation_top test failed");
    end
    $finish;
  end

endmodule
